FILE: hw/rtl/prc_pkg.sv
// Shared types and constants of the projective remap coordinate generator.
`timescale 1ns / 1ps
package prc_pkg;

   // Field and arithmetic widths
   localparam int COORD_W   = 12;                 // pixel index
   localparam int DIM_W     = 13;                 // image dimension register
   localparam int MAX_DIM   = 4096;
   localparam int SUB_BITS  = 8;                  // fractional bits of result
   localparam int OUT_W     = 20;                 // result coordinate width
   localparam int COEF_W    = 32;                 // signed Q12.20
   localparam int OFS_W     = COORD_W + 1;        // signed centred offset
   localparam int PROD_W    = COEF_W + OFS_W;     // one coefficient product
   localparam int SUM_W     = PROD_W + 2;         // two products plus a constant
   localparam int Z_W       = SUM_W;              // magnitude of denominator
   localparam int A_W       = SUM_W + SUB_BITS + 1; // magnitude of scaled numerator
   localparam int Q_W       = 22;                 // quotient bits kept
   localparam int R_W       = Z_W + 1;            // partial remainder
   localparam int TW_W      = 26;                 // signed doubled position
   localparam int DIV_LAT   = Q_W + 1;
   localparam int LAT       = DIV_LAT + 6;        // input to result, in cycles

   // Register map
   localparam int ADDR_W    = 6;
   localparam logic [2:0] REG_COEF0  = 3'd0;
   localparam logic [2:0] REG_COEF1  = 3'd1;
   localparam logic [2:0] REG_COEF2  = 3'd2;
   localparam logic [2:0] REG_COEF3  = 3'd3;
   localparam logic [2:0] REG_COEF8  = 3'd4;
   localparam logic [2:0] REG_WIDTH  = 3'd5;
   localparam logic [2:0] REG_HEIGHT = 3'd6;

   typedef struct packed {
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] src_x;
      logic [OUT_W-1:0] src_y;
      logic             in_range;
   } rsp_type;

endpackage

FILE: hw/rtl/prc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module prc_divider (
   input  logic                       clock,
   input  logic [prc_pkg::A_W-1:0]    in_a,
   input  logic [prc_pkg::Z_W-1:0]    in_z,
   input  logic                       in_neg,
   output logic [prc_pkg::Q_W-1:0]    quo,
   output logic                       rem_nz,
   output logic                       ovf,
   output logic                       neg
);
   localparam int QW = prc_pkg::Q_W;
   localparam int RW = prc_pkg::R_W;
   localparam int ZW = prc_pkg::Z_W;
   localparam int AW = prc_pkg::A_W;

   logic [RW-1:0] rem_ff [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [QW-1:0] quo_ff [0:QW];
   logic [ZW-1:0] z_ff   [0:QW];
   logic          ovf_ff [0:QW];
   logic          neg_ff [0:QW];

   logic [RW-1:0] top_in;
   assign top_in = RW'(in_a[AW-1:QW]);

   // Load: upper numerator bits seed the remainder; flag quotients too wide
   always_ff @(posedge clock) begin
      rem_ff[0] <= top_in;
      low_ff[0] <= in_a[QW-1:0];
      quo_ff[0] <= '0;
      z_ff[0]   <= in_z;
      ovf_ff[0] <= top_in >= RW'(in_z);
      neg_ff[0] <= in_neg;
   end

   // One compare and subtract per stage
   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [RW-1:0] trial_in;
      logic          fit_in;
      assign trial_in = {rem_ff[k-1][RW-2:0], low_ff[k-1][QW-1]};
      assign fit_in   = trial_in >= RW'(z_ff[k-1]);
      always_ff @(posedge clock) begin
         rem_ff[k] <= fit_in ? trial_in - RW'(z_ff[k-1]) : trial_in;
         low_ff[k] <= {low_ff[k-1][QW-2:0], 1'b0};
         quo_ff[k] <= {quo_ff[k-1][QW-2:0], fit_in};
         z_ff[k]   <= z_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   assign quo    = quo_ff[QW];
   assign rem_nz = rem_ff[QW] != '0;
   assign ovf    = ovf_ff[QW];
   assign neg    = neg_ff[QW];
endmodule

FILE: hw/rtl/projective_remap_coordinates.sv
// Top level: homography coordinate generator with register file and pipeline.
//
//   channel | ports                      | handshake
//   --------+----------------------------+--------------------------------
//   request | start, busy, req_data      | taken when start & !busy
//   result  | rsp_valid, rsp_data        | one cycle strobe, no back-pressure
//   config  | psel..pwdata, prdata       | APB write on psel&penable&pwrite
//
// One item enters every clock; busy is always low. Each result leaves
// after its item has passed stages 1 to 4, the 22-step divider chain, F1 and F2.
// Synchronous reset clears the valid pipeline and loads the identity matrix
// at 640x480. The receiver cannot stall, so nothing is held.
`timescale 1ns / 1ps
module projective_remap_coordinates (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  prc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output prc_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [prc_pkg::ADDR_W-1:0]    paddr,
   input  logic [63:0]                   pwdata,
   output logic [63:0]                   prdata,
   output logic                          pready
);
   localparam int CW = prc_pkg::COEF_W;
   localparam int OW = prc_pkg::OFS_W;
   localparam int PW = prc_pkg::PROD_W;
   localparam int SW = prc_pkg::SUM_W;
   localparam int AW = prc_pkg::A_W;
   localparam int ZW = prc_pkg::Z_W;
   localparam int QW = prc_pkg::Q_W;
   localparam int TW = prc_pkg::TW_W;
   localparam int DW = prc_pkg::DIM_W;
   localparam int SB = prc_pkg::SUB_BITS;

   // Configuration registers
   logic [63:0]   coef_ff [0:3];
   logic [CW-1:0] coef8_ff;
   logic [DW-1:0] width_ff, height_ff;
   logic          wr_en;
   logic [2:0]    reg_idx;

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign reg_idx = paddr[5:3];
   assign wr_en   = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= 64'd1048576;
         coef_ff[1] <= 64'd0;
         coef_ff[2] <= 64'd1048576;
         coef_ff[3] <= 64'd0;
         coef8_ff   <= 32'd1048576;
         width_ff   <= 13'd640;
         height_ff  <= 13'd480;
      end else if (wr_en) begin
         case (reg_idx)
            prc_pkg::REG_COEF0:  coef_ff[0] <= pwdata;
            prc_pkg::REG_COEF1:  coef_ff[1] <= pwdata;
            prc_pkg::REG_COEF2:  coef_ff[2] <= pwdata;
            prc_pkg::REG_COEF3:  coef_ff[3] <= pwdata;
            prc_pkg::REG_COEF8:  coef8_ff   <= pwdata[CW-1:0];
            prc_pkg::REG_WIDTH:  width_ff   <= pwdata[DW-1:0];
            prc_pkg::REG_HEIGHT: height_ff  <= pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         prc_pkg::REG_COEF0:  prdata = coef_ff[0];
         prc_pkg::REG_COEF1:  prdata = coef_ff[1];
         prc_pkg::REG_COEF2:  prdata = coef_ff[2];
         prc_pkg::REG_COEF3:  prdata = coef_ff[3];
         prc_pkg::REG_COEF8:  prdata = 64'(coef8_ff);
         prc_pkg::REG_WIDTH:  prdata = 64'(width_ff);
         prc_pkg::REG_HEIGHT: prdata = 64'(height_ff);
         default:             prdata = '0;
      endcase
   end

   // Matrix entries and clamped dimensions
   logic signed [CW-1:0] m [0:8];
   logic [DW-1:0]        dim_w, dim_h;
   logic [DW-2:0]        cx, cy;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m[2*i]   = coef_ff[i][CW-1:0];
         m[2*i+1] = coef_ff[i][63:CW];
      end
      m[8]  = coef8_ff;
      dim_w = (width_ff  > DW'(prc_pkg::MAX_DIM)) ? DW'(prc_pkg::MAX_DIM) : width_ff;
      dim_h = (height_ff > DW'(prc_pkg::MAX_DIM)) ? DW'(prc_pkg::MAX_DIM) : height_ff;
      cx    = dim_w[DW-1:1];
      cy    = dim_h[DW-1:1];
   end

   // Valid bits travel alongside the data
   logic [prc_pkg::LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[prc_pkg::LAT-2:0], start};
   end

   // Stage 1: center the position
   logic signed [OW-1:0] dx_ff, dy_ff;
   always_ff @(posedge clock) begin
      dx_ff <= $signed({1'b0, req_data.out_col}) - $signed({1'b0, cx});
      dy_ff <= $signed({1'b0, req_data.out_row}) - $signed({1'b0, cy});
   end

   // Stage 2: six coefficient products
   logic signed [PW-1:0] prod_ff [0:5];
   always_ff @(posedge clock) begin
      prod_ff[0] <= m[0] * dx_ff;
      prod_ff[1] <= m[1] * dy_ff;
      prod_ff[2] <= m[3] * dx_ff;
      prod_ff[3] <= m[4] * dy_ff;
      prod_ff[4] <= m[6] * dx_ff;
      prod_ff[5] <= m[7] * dy_ff;
   end

   // Stage 3: sum into numerators and denominator
   logic signed [SW-1:0] nx_ff, ny_ff, z_ff;
   always_ff @(posedge clock) begin
      nx_ff <= SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(m[2]);
      ny_ff <= SW'(prod_ff[2]) + SW'(prod_ff[3]) + SW'(m[5]);
      z_ff  <= SW'(prod_ff[4]) + SW'(prod_ff[5]) + SW'(m[8]);
   end

   // Stage 4: make the denominator positive, split numerators into sign/magnitude
   logic signed [SW-1:0] nxs, nys;
   logic [SW-1:0]        zmag;
   logic [AW-1:0]        ax_ff, ay_ff;
   logic [ZW-1:0]        zm_ff;
   logic                 xneg_ff, yneg_ff, zzero_ff;

   always_comb begin
      nxs  = z_ff[SW-1] ? -nx_ff : nx_ff;
      nys  = z_ff[SW-1] ? -ny_ff : ny_ff;
      zmag = z_ff[SW-1] ? SW'(-z_ff) : SW'(z_ff);
   end

   always_ff @(posedge clock) begin
      ax_ff    <= {(nxs[SW-1] ? SW'(-nxs) : SW'(nxs)), {(SB + 1){1'b0}}};
      ay_ff    <= {(nys[SW-1] ? SW'(-nys) : SW'(nys)), {(SB + 1){1'b0}}};
      xneg_ff  <= nxs[SW-1];
      yneg_ff  <= nys[SW-1];
      zm_ff    <= zmag;
      zzero_ff <= z_ff == '0;
   end

   // Zero-denominator flag rides along the divider chain
   logic [prc_pkg::DIV_LAT-1:0] zz_ff;
   always_ff @(posedge clock) begin
      zz_ff <= {zz_ff[prc_pkg::DIV_LAT-2:0], zzero_ff};
   end

   // Dividers for both axes
   logic [QW-1:0] qx, qy;
   logic          rx_nz, ry_nz, ox, oy, negx, negy;

   prc_divider u_div_x (
      .clock (clock), .in_a (ax_ff), .in_z (zm_ff), .in_neg (xneg_ff),
      .quo (qx), .rem_nz (rx_nz), .ovf (ox), .neg (negx)
   );

   prc_divider u_div_y (
      .clock (clock), .in_a (ay_ff), .in_z (zm_ff), .in_neg (yneg_ff),
      .quo (qy), .rem_nz (ry_nz), .ovf (oy), .neg (negy)
   );

   // Stage F1: floor quotient, add doubled center plus one half
   logic signed [TW-1:0] qxs, qys, offx, offy;
   logic signed [TW-1:0] twx_ff, twy_ff;
   logic                 fx_ff, fy_ff, bad_ff;

   always_comb begin
      qxs  = negx ? -(TW'(qx) + TW'(rx_nz)) : TW'(qx);
      qys  = negy ? -(TW'(qy) + TW'(ry_nz)) : TW'(qy);
      offx = TW'({cx, 1'b1}) <<< SB;
      offy = TW'({cy, 1'b1}) <<< SB;
   end

   always_ff @(posedge clock) begin
      twx_ff <= qxs + offx;
      twy_ff <= qys + offy;
      fx_ff  <= rx_nz;
      fy_ff  <= ry_nz;
      bad_ff <= ox | oy | zz_ff[prc_pkg::DIV_LAT-1];
   end

   // Stage F2: bounds test and output register
   logic signed [TW-1:0] bndx, bndy, whx, why;
   logic                 okx, oky, ok;

   always_comb begin
      bndx = (TW'($signed({1'b0, dim_w})) - TW'(1)) <<< SB;
      bndy = (TW'($signed({1'b0, dim_h})) - TW'(1)) <<< SB;
      whx  = twx_ff >>> 1;
      why  = twy_ff >>> 1;
      okx  = !twx_ff[TW-1] && !(whx > bndx || (whx == bndx && (fx_ff || twx_ff[0])));
      oky  = !twy_ff[TW-1] && !(why > bndy || (why == bndy && (fy_ff || twy_ff[0])));
      ok   = okx && oky && !bad_ff;
   end

   always_ff @(posedge clock) begin
      rsp_data.src_x    <= ok ? whx[prc_pkg::OUT_W-1:0] : '0;
      rsp_data.src_y    <= ok ? why[prc_pkg::OUT_W-1:0] : '0;
      rsp_data.in_range <= ok;
   end

   assign rsp_valid = vld_ff[prc_pkg::LAT-1];
endmodule
